FILE: rtl/idps_pkg.sv
package idps_pkg;
  localparam int MAX_NODES = 16;
  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int ID_W = 5;
  localparam int CNT_W = 5;
  localparam int DIST_W = 4;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_NODES);
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
endpackage

FILE: rtl/idps_ram.sv
module idps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/iterative_deepening_path_search_unit.sv
// edge write: the row is read, then written back with the edge bit; no result
// query: distance sweep over adjacency rows, level by level out from the goal node,
// then a walk from the source node that emits one path node per step
// one transaction in work at a time: in_tready is high only in the idle state
// reset (rst_n low, synchronous): all edges cleared via row valid flags, node_count = 16
module iterative_deepening_path_search_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // from_node[4:0], to_node[9:5], edge_present[10]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // found[0], node_id[5:1]
  output logic        out_tlast   // last
);
  localparam int N = idps_pkg::MAX_NODES;
  localparam int IW = idps_pkg::IDX_W;
  localparam int DW = idps_pkg::DIST_W;
  localparam int CW = idps_pkg::CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WR_RD = 4'd1;
  localparam logic [3:0] S_WR_UPD = 4'd2;
  localparam logic [3:0] S_LVL = 4'd3;
  localparam logic [3:0] S_BRD = 4'd4;
  localparam logic [3:0] S_BCHK = 4'd5;
  localparam logic [3:0] S_WOUT = 4'd6;
  localparam logic [3:0] S_WRD = 4'd7;
  localparam logic [3:0] S_WSCAN = 4'd8;
  localparam logic [3:0] S_FAIL = 4'd9;

  logic [3:0]    state_r;
  logic [CW-1:0] ncfg_r;
  logic [N-1:0]  rvalid_r;
  logic [IW-1:0] u_r, v_r, src_r;
  logic          wpres_r;
  logic [N-1:0]  seen_r, front_r, next_r;
  logic [DW-1:0] level_r, du_r;
  logic [DW-1:0] dist_r [N];
  logic          ov_r, olast_r, ofound_r;
  logic [4:0]    oid_r;

  logic [N-1:0]  rdata, row, live, nxt_mask;
  logic          we;
  logic [N-1:0]  wdata;
  logic [CW-1:0] n;
  logic [4:0]    fid, tid;
  logic          hit;

  assign fid = in_tdata[4:0];
  assign tid = in_tdata[9:5];
  assign n = (ncfg_r > idps_pkg::MAX_N) ? idps_pkg::MAX_N : ncfg_r;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      live[i] = (CW'(i) < n);
    end
  end

  assign row = rvalid_r[u_r] ? rdata : '0;
  assign nxt_mask = next_r | ((!seen_r[u_r] && ((row & live & front_r) != '0))
                              ? (N'(1) << u_r) : '0);
  assign hit = row[v_r] && seen_r[v_r] && live[v_r] &&
               ((DW+1)'(dist_r[v_r]) + (DW+1)'(1) == (DW+1)'(du_r));

  always_comb begin
    wdata = row;
    wdata[v_r] = wpres_r;
  end
  assign we = (state_r == S_WR_UPD);

  idps_ram #(.WIDTH(N), .DEPTH(N)) u_adj (
    .clk(clk), .we(we), .waddr(u_r), .wdata(wdata), .raddr(u_r), .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata = {2'b00, oid_r, ofound_r};
  assign out_tlast = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ncfg_r <= idps_pkg::MAX_N;
      rvalid_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ncfg_r <= cfg_data;
      end
      if (ov_r && out_tready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            wpres_r <= in_tdata[10];
            src_r <= IW'(fid - 5'd1);
            if (in_tuser == idps_pkg::MODE_WRITE) begin
              u_r <= IW'(fid - 5'd1);
              v_r <= IW'(tid - 5'd1);
              if (fid >= 5'd1 && fid <= idps_pkg::MAX_N &&
                  tid >= 5'd1 && tid <= idps_pkg::MAX_N) begin
                state_r <= S_WR_RD;
              end
            end else if (fid < 5'd1 || fid > n || tid < 5'd1 || tid > n) begin
              state_r <= S_FAIL;
            end else begin
              seen_r <= N'(1) << IW'(tid - 5'd1);
              front_r <= N'(1) << IW'(tid - 5'd1);
              dist_r[IW'(tid - 5'd1)] <= '0;
              level_r <= '0;
              state_r <= S_LVL;
            end
          end
        end
        S_WR_RD: state_r <= S_WR_UPD;
        S_WR_UPD: begin
          rvalid_r[u_r] <= 1'b1;
          state_r <= S_IDLE;
        end
        S_LVL: begin
          if (seen_r[src_r]) begin
            u_r <= src_r;
            du_r <= dist_r[src_r];
            state_r <= S_WOUT;
          end else if (front_r == '0) begin
            state_r <= S_FAIL;
          end else begin
            level_r <= level_r + DW'(1);
            next_r <= '0;
            u_r <= '0;
            state_r <= S_BRD;
          end
        end
        S_BRD: state_r <= S_BCHK;
        S_BCHK: begin
          if (!seen_r[u_r] && ((row & live & front_r) != '0)) begin
            dist_r[u_r] <= level_r;
          end
          next_r <= nxt_mask;
          if (CW'(u_r) == n - CW'(1)) begin
            seen_r <= seen_r | nxt_mask;
            front_r <= nxt_mask;
            state_r <= S_LVL;
          end else begin
            u_r <= u_r + IW'(1);
            state_r <= S_BRD;
          end
        end
        S_WOUT: begin
          if (!ov_r) begin
            ov_r <= 1'b1;
            ofound_r <= 1'b1;
            oid_r <= 5'(u_r) + 5'd1;
            olast_r <= (du_r == '0);
            state_r <= (du_r == '0) ? S_IDLE : S_WRD;
          end
        end
        S_WRD: begin
          v_r <= '0;
          state_r <= S_WSCAN;
        end
        S_WSCAN: begin
          if (hit) begin
            u_r <= v_r;
            du_r <= dist_r[v_r];
            state_r <= S_WOUT;
          end else if (CW'(v_r) == n - CW'(1)) begin
            u_r <= '0;
            du_r <= '0;
            state_r <= S_WOUT;
          end else begin
            v_r <= v_r + IW'(1);
          end
        end
        S_FAIL: begin
          if (!ov_r) begin
            ov_r <= 1'b1;
            ofound_r <= 1'b0;
            oid_r <= '0;
            olast_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       mode;
    logic [4:0] from_node;
    logic [4:0] to_node;
    logic       edge_present;
  } graph_item_t;

  typedef struct packed {
    logic       found;
    logic [4:0] node_id;
    logic       last;
  } path_node_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  iterative_deepening_path_search_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  graph_item_t pending_items[$];
  path_node_t  expected_path[$];
  logic [15:0] adj_rows[16];
  logic [4:0]  node_count_q;
  int          mismatch_count;
  int          in_idle_pct;
  int          out_stall_pct;
  bit          hold_sender;
  bit          in_taken;

  // shortest lexicographically smallest path, same as the first one deepening finds
  task automatic predict_search(input graph_item_t it);
    int n;
    int s;
    int g;
    int lvl;
    int u;
    int v;
    int cnt;
    int dist_to_goal[16];
    logic [15:0] seen;
    logic [15:0] frontier;
    logic [15:0] nxt;
    logic [15:0] live;
    path_node_t  r;
    n = (node_count_q > 16) ? 16 : node_count_q;
    live = (n >= 16) ? 16'hffff : ((16'h1 << n) - 16'h1);
    if (it.mode == idps_pkg::MODE_WRITE) begin
      if (it.from_node >= 1 && it.from_node <= 16 && it.to_node >= 1 && it.to_node <= 16)
        adj_rows[it.from_node - 1][it.to_node - 1] = it.edge_present;
      return;
    end
    if (it.from_node < 1 || it.from_node > n || it.to_node < 1 || it.to_node > n) begin
      r = '{1'b0, 5'd0, 1'b1};
      expected_path.push_back(r);
      return;
    end
    s = it.from_node - 1;
    g = it.to_node - 1;
    for (u = 0; u < 16; u++) dist_to_goal[u] = -1;
    dist_to_goal[g] = 0;
    seen = 16'h1 << g;
    frontier = seen;
    lvl = 0;
    while (frontier != 0 && dist_to_goal[s] < 0) begin
      nxt = 0;
      lvl++;
      for (u = 0; u < n; u++)
        if (!seen[u] && (adj_rows[u] & live & frontier) != 0) begin
          dist_to_goal[u] = lvl;
          nxt[u] = 1'b1;
        end
      seen |= nxt;
      frontier = nxt;
    end
    if (dist_to_goal[s] < 0) begin
      r = '{1'b0, 5'd0, 1'b1};
      expected_path.push_back(r);
      return;
    end
    cnt = dist_to_goal[s] + 1;
    u = s;
    for (int d = 0; d < cnt; d++) begin
      r = '{1'b1, 5'(u + 1), (d + 1 == cnt)};
      expected_path.push_back(r);
      for (v = 0; v < n; v++)
        if (adj_rows[u][v] && dist_to_goal[v] >= 0 && dist_to_goal[v] + 1 == dist_to_goal[u])
          break;
      if (v >= n) v = 0;
      u = v;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("iterative_deepening_path_search_unit: mismatch");
    $finish;
  end

  always @(posedge clk)
    in_taken <= in_tvalid && in_tready;

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
    end else if (pending_items.size() > 0 && !hold_sender &&
                 $urandom_range(99) >= in_idle_pct) begin
      graph_item_t it;
      it = pending_items.pop_front();
      predict_search(it);
      in_tvalid <= 1'b1;
      in_tuser <= it.mode;
      in_tdata <= {5'd0, it.edge_present, it.to_node, it.from_node};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk)
    out_tready <= rst_n && ($urandom_range(99) >= out_stall_pct);

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      path_node_t got;
      path_node_t want;
      got = '{out_tdata[0], out_tdata[5:1], out_tlast};
      if (expected_path.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_path.pop_front();
        if (got.found !== want.found || got.node_id !== want.node_id ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("expected %p got %p", want, got);
        end
      end
    end
  end

  function automatic graph_item_t mk(logic m, int f, int t, logic e);
    graph_item_t it;
    it = '{m, 5'(f), 5'(t), e};
    return it;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() > 0 || in_tvalid || expected_path.size() > 0)
      @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_node_count(input logic [4:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    node_count_q = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int items, input int idle, input int stall, input int nmax);
    int k;
    in_idle_pct = idle;
    out_stall_pct = stall;
    for (k = 0; k < items; k++) begin
      case ($urandom_range(9))
        0: pending_items.push_back(mk($urandom_range(1), $urandom_range(31),
                                     $urandom_range(31), $urandom_range(1)));
        1, 2, 3: pending_items.push_back(mk(idps_pkg::MODE_QUERY, $urandom_range(1, nmax),
                                            $urandom_range(1, nmax), 1'b0));
        default: pending_items.push_back(mk(idps_pkg::MODE_WRITE, $urandom_range(1, nmax),
                                            $urandom_range(1, nmax), $urandom_range(3) != 0));
      endcase
    end
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    hold_sender = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    mismatch_count = 0;
    node_count_q = idps_pkg::MAX_N;
    foreach (adj_rows[i]) adj_rows[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: chain, branches, self, bad ids, no path
    pending_items.push_back(mk(idps_pkg::MODE_QUERY, 1, 16, 0));
    pending_items.push_back(mk(idps_pkg::MODE_QUERY, 3, 3, 0));
    pending_items.push_back(mk(idps_pkg::MODE_QUERY, 0, 2, 0));
    pending_items.push_back(mk(idps_pkg::MODE_QUERY, 2, 17, 0));
    pending_items.push_back(mk(idps_pkg::MODE_WRITE, 1, 2, 1));
    pending_items.push_back(mk(idps_pkg::MODE_WRITE, 2, 16, 1));
    pending_items.push_back(mk(idps_pkg::MODE_WRITE, 1, 3, 1));
    pending_items.push_back(mk(idps_pkg::MODE_WRITE, 3, 16, 1));
    pending_items.push_back(mk(idps_pkg::MODE_WRITE, 0, 5, 1));
    pending_items.push_back(mk(idps_pkg::MODE_WRITE, 31, 31, 1));
    pending_items.push_back(mk(idps_pkg::MODE_QUERY, 1, 16, 0));
    pending_items.push_back(mk(idps_pkg::MODE_WRITE, 2, 16, 0));
    pending_items.push_back(mk(idps_pkg::MODE_QUERY, 1, 16, 1));
    pending_items.push_back(mk(idps_pkg::MODE_QUERY, 16, 1, 0));
    for (int i = 4; i < 16; i++)
      pending_items.push_back(mk(idps_pkg::MODE_WRITE, i, i + 1, 1));
    wait_idle();
    hold_sender = 1'b1;
    pending_items.push_back(mk(idps_pkg::MODE_QUERY, 4, 16, 0));
    hold_sender = 1'b0;
    wait_idle();

    random_phase(20, 0, 0, 16);
    write_node_count(5'd1);
    random_phase(10, 61, 0, 2);
    write_node_count(5'd0);
    pending_items.push_back(mk(idps_pkg::MODE_QUERY, 1, 1, 0));
    wait_idle();
    write_node_count(5'd31);
    random_phase(30, 0, 61, 16);
    write_node_count(5'd6);
    random_phase(30, 27, 27, 7);
    write_node_count(5'd16);
    random_phase(25, 61, 0, 16);

    if (mismatch_count == 0 && expected_path.size() == 0) begin
      $display("iterative_deepening_path_search_unit: match");
    end else begin
      $display("iterative_deepening_path_search_unit: mismatch");
    end
    $finish;
  end
endmodule
